// ===== rtl/grid_surface_quad_mesh_unit_defines.svh =====
// Assertion macros shared by the grid surface quad mesh RTL.
`ifndef GRID_SURFACE_QUAD_MESH_UNIT_DEFINES_SVH
`define GRID_SURFACE_QUAD_MESH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and suspended during reset.
`define GSQM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and suspended during reset.
`define GSQM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gsqm_pkg.sv =====
// Constants, types and helpers for the grid surface quad mesh unit.
`default_nettype none

package gsqm_pkg;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 13;
    localparam int INDEX_W   = 24;
    localparam int WORD_W    = INDEX_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int TEX_W     = FRAC_BITS + 1;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

    // Reset value of both grid dimension registers.
    localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;

    // Float32 pattern of -1.0, the "no point" marker on x.
    localparam logic [COORD_W-1:0] NEG_ONE_BITS = 32'hBF80_0000;

    // 1.0 in unsigned 1.16 fixed point.
    localparam logic [TEX_W-1:0] TEX_ONE = 17'h1_0000;

    // Index word: the flag marks a missing vertex.
    typedef struct packed {
        logic                  invalid;
        logic [INDEX_W-1:0]    index;
    } index_word_t;

    localparam index_word_t INVALID_WORD = '{invalid: 1'b1, index: '0};

    // True when the exponent field is not all ones.
    function automatic logic is_finite(input logic [COORD_W-1:0] bits);
        is_finite = (bits[30:23] != 8'hFF);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gsqm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module gsqm_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/grid_surface_quad_mesh_unit.sv =====
// Top level of the grid surface to quad mesh converter.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid / in_stall       x_bits, y_bits, z_bits
//   result    out        out_valid / out_stall     vertex or quad record fields
//   config    in         cfg_write_enable          cfg_index, cfg_write_data
//
// A valid point passes through accept, line store read and update, 16 steps of
// the bit-serial texture divider, and the load into the output register.
// A point that is not valid passes only through accept and the line store read and update.
// The next point is accepted while earlier results still wait in the output register.
// Reset clears the counters, neighbor indices and output flags; the line store is not cleared.
// A stalled output holds its transaction; a point that finishes meanwhile waits for it.
`default_nettype none

`include "grid_surface_quad_mesh_unit_defines.svh"

module grid_surface_quad_mesh_unit #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port.
    input  wire logic                            cfg_write_enable,
    input  wire logic [gsqm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gsqm_pkg::CFG_W-1:0]      cfg_write_data,
    // Point input channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [gsqm_pkg::COORD_W-1:0]    x_bits,
    input  wire logic [gsqm_pkg::COORD_W-1:0]    y_bits,
    input  wire logic [gsqm_pkg::COORD_W-1:0]    z_bits,
    // Result channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 item_kind,
    output logic                                 last_of_run,
    output logic      [gsqm_pkg::INDEX_W-1:0]    vertex_number,
    output logic      [gsqm_pkg::COORD_W-1:0]    out_x,
    output logic      [gsqm_pkg::COORD_W-1:0]    out_y,
    output logic      [gsqm_pkg::COORD_W-1:0]    out_z,
    output logic      [gsqm_pkg::TEX_W-1:0]      tex_u,
    output logic      [gsqm_pkg::TEX_W-1:0]      tex_v,
    output logic      [gsqm_pkg::INDEX_W-1:0]    corner_upper_left,
    output logic      [gsqm_pkg::INDEX_W-1:0]    corner_upper_right,
    output logic      [gsqm_pkg::INDEX_W-1:0]    corner_lower_right,
    output logic      [gsqm_pkg::INDEX_W-1:0]    corner_lower_left
);

    import gsqm_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DCW   = $clog2(FRAC_BITS);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    // Control registers.
    logic [1:0]          state_reg,      state_next;
    logic [CFG_W-1:0]    grid_columns_reg;
    logic [CFG_W-1:0]    grid_rows_reg;
    logic [CW-1:0]       col_reg,        col_next;
    logic [RW-1:0]       row_reg,        row_next;
    logic [WORD_W-1:0]   vcount_reg,     vcount_next;
    index_word_t         left_reg,       left_next;
    index_word_t         upleft_reg,     upleft_next;
    logic [DCW-1:0]      div_cnt_reg,    div_cnt_next;
    logic                out_valid_reg,  out_valid_next;
    logic                phase_reg,      phase_next;

    // Payload registers of the point at work.
    logic [COORD_W-1:0]  px_reg, py_reg, pz_reg;
    logic                pt_valid_reg;
    logic [INDEX_W-1:0]  vnum_reg;
    logic                quad_reg;
    logic [INDEX_W-1:0]  cul_reg, cur_reg, cll_reg;
    logic [CW-1:0]       rem_u_reg, den_u_reg;
    logic [RW-1:0]       rem_v_reg, den_v_reg;
    logic                sat_u_reg, sat_v_reg;
    logic [FRAC_BITS-1:0] q_u_reg, q_v_reg;

    // Output register payload.
    logic                has_quad_reg;
    logic [INDEX_W-1:0]  o_vnum_reg;
    logic [COORD_W-1:0]  o_x_reg, o_y_reg, o_z_reg;
    logic [TEX_W-1:0]    o_u_reg, o_v_reg;
    logic [INDEX_W-1:0]  o_cul_reg, o_cur_reg, o_clr_reg, o_cll_reg;

    // Combinational signals.
    logic                in_accept;
    logic                out_accept;
    logic                buf_free;
    logic                out_load;
    logic [31:0]         cols_raw, rows_raw, cols_lim, rows_lim, cd32, rd32;
    logic [CW-1:0]       cd;
    logic [RW-1:0]       rd;
    logic [RW-1:0]       row_clamp;
    logic [RW-1:0]       v_num;
    logic                end_row, end_grid;
    index_word_t         upper_word, cur_word;
    logic                quad_now;
    logic                ram_we;
    logic [WORD_W-1:0]   ram_rdata;
    logic [CW:0]         t_u, d_u;
    logic [RW:0]         t_v, d_v;
    logic                ge_u, ge_v;

    // Handshakes.
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign buf_free   = !out_valid_reg || (out_accept && (phase_reg || !has_quad_reg));
    assign out_load   = (state_reg == ST_LOAD) && buf_free;

    // Effective grid dimensions and texture denominators.
    always_comb
    begin
        cols_raw = 32'(grid_columns_reg);
        rows_raw = 32'(grid_rows_reg);
        if (cols_raw == 32'd0)
        begin
            cols_lim = 32'd1;
        end
        else if (cols_raw > 32'(MAX_COLUMNS))
        begin
            cols_lim = 32'(MAX_COLUMNS);
        end
        else
        begin
            cols_lim = cols_raw;
        end
        if (rows_raw == 32'd0)
        begin
            rows_lim = 32'd1;
        end
        else if (rows_raw > 32'(MAX_ROWS))
        begin
            rows_lim = 32'(MAX_ROWS);
        end
        else
        begin
            rows_lim = rows_raw;
        end
        cd32      = (cols_lim > 32'd1) ? cols_lim - 32'd1 : 32'd1;
        rd32      = (rows_lim > 32'd1) ? rows_lim - 32'd1 : 32'd1;
        cd        = cd32[CW-1:0];
        rd        = rd32[RW-1:0];
        row_clamp = (32'(row_reg) > rd32) ? rd : row_reg;
        v_num     = rd - row_clamp;
        end_row   = (32'(col_reg) + 32'd1) >= cols_lim;
        end_grid  = (32'(row_reg) + 32'd1) >= rows_lim;
    end

    // Neighbor words and the quad decision, valid in the read state.
    always_comb
    begin
        upper_word = (row_reg == '0) ? INVALID_WORD : index_word_t'(ram_rdata);
        cur_word   = pt_valid_reg ? index_word_t'({1'b0, vcount_reg[INDEX_W-1:0]})
                                  : INVALID_WORD;
        quad_now   = pt_valid_reg && !left_reg.invalid && !upper_word.invalid
                     && !upleft_reg.invalid;
    end

    assign ram_we = (state_reg == ST_READ);

    // Line store of the previous row's vertex indices.
    gsqm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (cur_word),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // One restoring division step for each texture coordinate.
    always_comb
    begin
        t_u  = {rem_u_reg, 1'b0};
        t_v  = {rem_v_reg, 1'b0};
        ge_u = (t_u >= {1'b0, den_u_reg});
        ge_v = (t_v >= {1'b0, den_v_reg});
        d_u  = ge_u ? t_u - {1'b0, den_u_reg} : t_u;
        d_v  = ge_v ? t_v - {1'b0, den_v_reg} : t_v;
    end

    // Next-state logic of the sequencer, position counters and output flags.
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        vcount_next    = vcount_reg;
        left_next      = left_reg;
        upleft_next    = upleft_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (pt_valid_reg)
                begin
                    vcount_next = vcount_reg + 1'b1;
                end
                if (end_row)
                begin
                    col_next    = '0;
                    left_next   = INVALID_WORD;
                    upleft_next = INVALID_WORD;
                    if (end_grid)
                    begin
                        row_next    = '0;
                        vcount_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next    = col_reg + 1'b1;
                    left_next   = cur_word;
                    upleft_next = upper_word;
                end
                div_cnt_next = '0;
                state_next   = pt_valid_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(FRAC_BITS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (buf_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: vertex first, then the quad if there is one.
        if (out_load)
        begin
            out_valid_next = 1'b1;
            phase_next     = 1'b0;
        end
        else if (out_accept)
        begin
            if (!phase_reg && has_quad_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            vcount_reg    <= '0;
            left_reg      <= INVALID_WORD;
            upleft_reg    <= INVALID_WORD;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            vcount_reg    <= vcount_next;
            left_reg      <= left_next;
            upleft_reg    <= upleft_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= DIM_RESET;
            grid_rows_reg    <= DIM_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: grid_columns_reg <= cfg_write_data;
                CFG_ROWS:    grid_rows_reg    <= cfg_write_data;
                default:     grid_rows_reg    <= grid_rows_reg;
            endcase
        end
    end

    // Payload of the point at work: capture, neighbor lookup, divider.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg       <= x_bits;
            py_reg       <= y_bits;
            pz_reg       <= z_bits;
            pt_valid_reg <= (x_bits != NEG_ONE_BITS) && is_finite(x_bits)
                            && is_finite(y_bits) && is_finite(z_bits);
        end
        if (state_reg == ST_READ)
        begin
            vnum_reg  <= vcount_reg[INDEX_W-1:0];
            quad_reg  <= quad_now;
            cul_reg   <= upleft_reg.index;
            cur_reg   <= upper_word.index;
            cll_reg   <= left_reg.index;
            rem_u_reg <= col_reg;
            den_u_reg <= cd;
            sat_u_reg <= (col_reg >= cd);
            rem_v_reg <= v_num;
            den_v_reg <= rd;
            sat_v_reg <= (v_num >= rd);
        end
        if (state_reg == ST_DIV)
        begin
            rem_u_reg <= d_u[CW-1:0];
            rem_v_reg <= d_v[RW-1:0];
            q_u_reg   <= {q_u_reg[FRAC_BITS-2:0], ge_u};
            q_v_reg   <= {q_v_reg[FRAC_BITS-2:0], ge_v};
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            has_quad_reg <= quad_reg;
            o_vnum_reg   <= vnum_reg;
            o_x_reg      <= px_reg;
            o_y_reg      <= py_reg;
            o_z_reg      <= pz_reg;
            o_u_reg      <= sat_u_reg ? TEX_ONE : {1'b0, q_u_reg};
            o_v_reg      <= sat_v_reg ? TEX_ONE : {1'b0, q_v_reg};
            o_cul_reg    <= cul_reg;
            o_cur_reg    <= cur_reg;
            o_clr_reg    <= vnum_reg;
            o_cll_reg    <= cll_reg;
        end
    end

    // Result fields: the vertex record in phase zero, the quad record in phase one.
    assign out_valid          = out_valid_reg;
    assign item_kind          = phase_reg;
    assign last_of_run        = phase_reg || !has_quad_reg;
    assign vertex_number      = phase_reg ? '0 : o_vnum_reg;
    assign out_x              = phase_reg ? '0 : o_x_reg;
    assign out_y              = phase_reg ? '0 : o_y_reg;
    assign out_z              = phase_reg ? '0 : o_z_reg;
    assign tex_u              = phase_reg ? '0 : o_u_reg;
    assign tex_v              = phase_reg ? '0 : o_v_reg;
    assign corner_upper_left  = phase_reg ? o_cul_reg : '0;
    assign corner_upper_right = phase_reg ? o_cur_reg : '0;
    assign corner_lower_right = phase_reg ? o_clr_reg : '0;
    assign corner_lower_left  = phase_reg ? o_cll_reg : '0;

    // Checks on the sequencer and the output register.
    `GSQM_ASSERT_NEXT(a_accept_reads_store, in_accept, state_reg == ST_READ, "read missed")
    `GSQM_ASSERT_NEXT(a_skip_invalid_point, ram_we && !pt_valid_reg, !in_stall, "not skipped")
    `GSQM_ASSERT_NEXT(a_quad_follows, out_accept && !last_of_run, out_valid && item_kind, "no quad")
    `GSQM_ASSERT_NOW(a_load_free, out_load, !out_valid || (!out_stall && last_of_run), "busy")

endmodule

`default_nettype wire

// ===== tb/grid_surface_quad_mesh_unit_checker.sv =====
// Checker for the grid surface quad mesh unit: predicts mesh records and compares the result channel.
module grid_surface_quad_mesh_unit_checker
    import gsqm_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_enable,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_write_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [COORD_W-1:0]   x_bits,
    input  logic [COORD_W-1:0]   y_bits,
    input  logic [COORD_W-1:0]   z_bits,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 item_kind,
    input  logic                 last_of_run,
    input  logic [INDEX_W-1:0]   vertex_number,
    input  logic [COORD_W-1:0]   out_x,
    input  logic [COORD_W-1:0]   out_y,
    input  logic [COORD_W-1:0]   out_z,
    input  logic [TEX_W-1:0]     tex_u,
    input  logic [TEX_W-1:0]     tex_v,
    input  logic [INDEX_W-1:0]   corner_upper_left,
    input  logic [INDEX_W-1:0]   corner_upper_right,
    input  logic [INDEX_W-1:0]   corner_lower_right,
    input  logic [INDEX_W-1:0]   corner_lower_left,
    output int                   fail_count,
    output int                   pending_records,
    output int                   grid_row,
    output int                   active_columns,
    output int                   vertex_records,
    output int                   quad_records
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_QUAD   = 1'b1;
    localparam int   PRINT_CAP   = 40;

    // One result record, laid out in port order.
    typedef struct packed {
        logic               kind;
        logic               last;
        logic [INDEX_W-1:0] vertex;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [TEX_W-1:0]   u;
        logic [TEX_W-1:0]   v;
        logic [INDEX_W-1:0] ul;
        logic [INDEX_W-1:0] ur;
        logic [INDEX_W-1:0] lr;
        logic [INDEX_W-1:0] ll;
    } mesh_rec_t;

    mesh_rec_t   expected_records[$];
    mesh_rec_t   observed;
    int          records_seen;

    // Shadow of the block's configuration and walk state.
    logic [CFG_W-1:0]   columns_reg;
    logic [CFG_W-1:0]   rows_reg;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [WORD_W-1:0]  vertex_count;
    index_word_t        line_store [0:MAX_COLUMNS-1];
    index_word_t        left_word;
    index_word_t        upper_left_word;

    assign observed = {item_kind, last_of_run, vertex_number, out_x, out_y, out_z, tex_u, tex_v,
                       corner_upper_left, corner_upper_right, corner_lower_right,
                       corner_lower_left};

    // A zero dimension counts as one, an oversized one as the maximum.
    function automatic int unsigned dim_limit(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    // Ratio in unsigned 1.16 fixed point, saturating at 1.0.
    function automatic logic [TEX_W-1:0] fixed_ratio(input int unsigned num, input int unsigned den);
        if (num >= den)
            return TEX_ONE;
        return TEX_W'((num << FRAC_BITS) / den);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("ERROR @%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                                      records_seen, name, got, want));
    endtask

    // Append one record at the tail of the expected queue.
    task automatic queue_record(input mesh_rec_t rec);
        expected_records.insert(expected_records.size(), rec);
    endtask

    // Compare one result transaction with the oldest expected record.
    task automatic check_record(input mesh_rec_t got);
        mesh_rec_t want;
        if (expected_records.size() == 0)
        begin
            report_mismatch($sformatf("record %0d arrived with nothing expected", records_seen));
        end
        else
        begin
            want = expected_records.pop_front();
            compare_field("item_kind", got.kind, want.kind);
            compare_field("last_of_run", got.last, want.last);
            compare_field("vertex_number", got.vertex, want.vertex);
            compare_field("out_x", got.x, want.x);
            compare_field("out_y", got.y, want.y);
            compare_field("out_z", got.z, want.z);
            compare_field("tex_u", got.u, want.u);
            compare_field("tex_v", got.v, want.v);
            compare_field("corner_upper_left", got.ul, want.ul);
            compare_field("corner_upper_right", got.ur, want.ur);
            compare_field("corner_lower_right", got.lr, want.lr);
            compare_field("corner_lower_left", got.ll, want.ll);
            if (want.kind == KIND_QUAD)
                quad_records++;
            else
                vertex_records++;
        end
        records_seen++;
    endtask

    // Work out the vertex record, and the quad record if the cell closes, for one point.
    task automatic predict_mesh_records(input logic [COORD_W-1:0] xb, input logic [COORD_W-1:0] yb,
                                        input logic [COORD_W-1:0] zb);
        int unsigned cols, rows, col, row, slot, col_div, row_div, row_clip;
        index_word_t upper;
        index_word_t cur;
        logic        point_ok;
        logic        makes_quad;
        mesh_rec_t   rec;
        cols = dim_limit(columns_reg, MAX_COLUMNS);
        rows = dim_limit(rows_reg, MAX_ROWS);
        col = col_pos;
        row = row_pos;
        slot = (col < MAX_COLUMNS) ? col : MAX_COLUMNS - 1;
        upper = (row > 0) ? line_store[slot] : INVALID_WORD;
        point_ok = (xb != NEG_ONE_BITS) && (xb[30:23] != 8'hFF) &&
                   (yb[30:23] != 8'hFF) && (zb[30:23] != 8'hFF);
        cur = INVALID_WORD;

        if (point_ok)
        begin
            col_div = (cols > 1) ? cols - 1 : 1;
            row_div = (rows > 1) ? rows - 1 : 1;
            row_clip = (row > row_div) ? row_div : row;
            cur.invalid = 1'b0;
            cur.index = vertex_count[INDEX_W-1:0];
            makes_quad = !left_word.invalid && !upper.invalid && !upper_left_word.invalid;

            rec = '0;
            rec.kind = KIND_VERTEX;
            rec.last = !makes_quad;
            rec.vertex = cur.index;
            rec.x = xb;
            rec.y = yb;
            rec.z = zb;
            rec.u = fixed_ratio(col, col_div);
            rec.v = fixed_ratio(row_div - row_clip, row_div);
            queue_record(rec);

            if (makes_quad)
            begin
                rec = '0;
                rec.kind = KIND_QUAD;
                rec.last = 1'b1;
                rec.ul = upper_left_word.index;
                rec.ur = upper.index;
                rec.lr = cur.index;
                rec.ll = left_word.index;
                queue_record(rec);
            end
            vertex_count = vertex_count + 1'b1;
        end

        // Advance the raster position; the end of the grid restarts the numbering.
        line_store[slot] = cur;
        if (col + 1 >= cols)
        begin
            col_pos = 0;
            left_word = INVALID_WORD;
            upper_left_word = INVALID_WORD;
            if (row + 1 >= rows)
            begin
                row_pos = 0;
                vertex_count = '0;
            end
            else
            begin
                row_pos = (row + 1) & 32'h0000_FFFF;
            end
        end
        else
        begin
            col_pos = col + 1;
            left_word = cur;
            upper_left_word = upper;
        end
    endtask

    // Watch all three ports on the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg = DIM_RESET;
            rows_reg = DIM_RESET;
            col_pos = 0;
            row_pos = 0;
            vertex_count = '0;
            left_word = INVALID_WORD;
            upper_left_word = INVALID_WORD;
            for (int i = 0; i < MAX_COLUMNS; i++)
                line_store[i] = '0;
            expected_records.delete();
            pending_records = 0;
            grid_row = 0;
            active_columns = MAX_COLUMNS;
        end
        else
        begin
            // A result transaction is checked before any new point is predicted.
            if (out_valid && !out_stall)
                check_record(observed);

            if (cfg_write_enable)
            begin
                if (cfg_index == CFG_COLUMNS)
                    columns_reg = cfg_write_data;
                else if (cfg_index == CFG_ROWS)
                    rows_reg = cfg_write_data;
            end

            if (in_valid && !in_stall)
                predict_mesh_records(x_bits, y_bits, z_bits);

            pending_records = expected_records.size();
            grid_row = row_pos;
            active_columns = dim_limit(columns_reg, MAX_COLUMNS);
        end
    end

endmodule

// ===== tb/grid_surface_quad_mesh_unit_tb.sv =====
// Testbench top for the grid surface quad mesh unit: stimulus, back-pressure and verdict.
module grid_surface_quad_mesh_unit_tb
    import gsqm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_POINTS = 700;
    localparam int CALM_POINTS   = 120;
    localparam int SETTLE_CYCLES = 25;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_PHASE    = 5;
    localparam int CYCLE_LIMIT   = 400000;

    // Float32 patterns used by the directed points.
    localparam logic [COORD_W-1:0] F_ZERO     = 32'h0000_0000;
    localparam logic [COORD_W-1:0] F_NEG_ZERO = 32'h8000_0000;
    localparam logic [COORD_W-1:0] F_ONE      = 32'h3F80_0000;
    localparam logic [COORD_W-1:0] F_MAX      = 32'h7F7F_FFFF;
    localparam logic [COORD_W-1:0] F_NEG_MAX  = 32'hFF7F_FFFF;
    localparam logic [COORD_W-1:0] F_MIN_SUB  = 32'h0000_0001;
    localparam logic [COORD_W-1:0] F_INF      = 32'h7F80_0000;
    localparam logic [COORD_W-1:0] F_NEG_INF  = 32'hFF80_0000;
    localparam logic [COORD_W-1:0] F_NAN      = 32'h7FC0_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_enable;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_write_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [COORD_W-1:0]   x_bits;
    logic [COORD_W-1:0]   y_bits;
    logic [COORD_W-1:0]   z_bits;
    logic                 out_valid;
    logic                 out_stall;
    logic                 item_kind;
    logic                 last_of_run;
    logic [INDEX_W-1:0]   vertex_number;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic [COORD_W-1:0]   out_z;
    logic [TEX_W-1:0]     tex_u;
    logic [TEX_W-1:0]     tex_v;
    logic [INDEX_W-1:0]   corner_upper_left;
    logic [INDEX_W-1:0]   corner_upper_right;
    logic [INDEX_W-1:0]   corner_lower_right;
    logic [INDEX_W-1:0]   corner_lower_left;

    int fail_count;
    int pending_records;
    int grid_row;
    int active_columns;
    int vertex_records;
    int quad_records;

    bit idle_enable   = 1'b1;
    bit long_hold_req = 1'b0;
    int points_sent   = 0;
    int phase_count   = 0;
    int cycle_count   = 0;

    grid_surface_quad_mesh_unit u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_index          (cfg_index),
        .cfg_write_data     (cfg_write_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .x_bits             (x_bits),
        .y_bits             (y_bits),
        .z_bits             (z_bits),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .item_kind          (item_kind),
        .last_of_run        (last_of_run),
        .vertex_number      (vertex_number),
        .out_x              (out_x),
        .out_y              (out_y),
        .out_z              (out_z),
        .tex_u              (tex_u),
        .tex_v              (tex_v),
        .corner_upper_left  (corner_upper_left),
        .corner_upper_right (corner_upper_right),
        .corner_lower_right (corner_lower_right),
        .corner_lower_left  (corner_lower_left)
    );

    grid_surface_quad_mesh_unit_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_index          (cfg_index),
        .cfg_write_data     (cfg_write_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .x_bits             (x_bits),
        .y_bits             (y_bits),
        .z_bits             (z_bits),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .item_kind          (item_kind),
        .last_of_run        (last_of_run),
        .vertex_number      (vertex_number),
        .out_x              (out_x),
        .out_y              (out_y),
        .out_z              (out_z),
        .tex_u              (tex_u),
        .tex_v              (tex_v),
        .corner_upper_left  (corner_upper_left),
        .corner_upper_right (corner_upper_right),
        .corner_lower_right (corner_lower_right),
        .corner_lower_left  (corner_lower_left),
        .fail_count         (fail_count),
        .pending_records    (pending_records),
        .grid_row           (grid_row),
        .active_columns     (active_columns),
        .vertex_records     (vertex_records),
        .quad_records       (quad_records)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d records outstanding.",
                     cycle_count, pending_records);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: short random stall bursts, and one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 6) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Random finite pattern, biased toward edge values.
    function automatic logic [COORD_W-1:0] finite_word();
        logic [COORD_W-1:0] w;
        w = $urandom();
        case ($urandom_range(0, 11))
            0: w = F_ZERO;
            1: w = F_NEG_ZERO;
            2: w = F_MAX;
            3: w = F_NEG_MAX;
            4: w = F_ONE;
            5: w = NEG_ONE_BITS + 1'b1;
            6: w[30:23] = 8'h00;
            default:
            begin
                if (w[30:23] == 8'hFF)
                    w[30:23] = 8'hFE;
            end
        endcase
        return w;
    endfunction

    // Infinity or NaN with a random sign and payload.
    function automatic logic [COORD_W-1:0] nonfinite_word();
        logic [COORD_W-1:0] w;
        w = $urandom();
        w[30:23] = 8'hFF;
        if ($urandom_range(0, 3) == 0)
            w[22:0] = '0;
        return w;
    endfunction

    // Mostly valid points; some are dropped by each of the validity rules, some keep -1.0 in y and z.
    task automatic make_point(output logic [COORD_W-1:0] xv, output logic [COORD_W-1:0] yv,
                              output logic [COORD_W-1:0] zv);
        xv = finite_word();
        yv = finite_word();
        zv = finite_word();
        case ($urandom_range(0, 19))
            0: xv = NEG_ONE_BITS;
            1: xv = nonfinite_word();
            2: yv = nonfinite_word();
            3: zv = nonfinite_word();
            4:
            begin
                yv = NEG_ONE_BITS;
                zv = NEG_ONE_BITS;
            end
            default: ;
        endcase
    endtask

    // Offer one point and hold it until the input transaction completes.
    task automatic send_point(input logic [COORD_W-1:0] xv, input logic [COORD_W-1:0] yv,
                              input logic [COORD_W-1:0] zv);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        x_bits <= xv;
        y_bits <= yv;
        z_bits <= zv;
        do
            @(posedge clk);
        while (in_stall);
        points_sent++;
        @(negedge clk);
    endtask

    // Stop sending and let every expected record drain, then let the pipeline empty.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_records != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_write_data <= val;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [COORD_W-1:0] px, py, pz;
        logic [CFG_W-1:0]   cols_val;
        logic [CFG_W-1:0]   rows_val;
        int                 phase_points;

        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = CFG_COLUMNS;
        cfg_write_data = '0;
        in_valid = 1'b0;
        x_bits = '0;
        y_bits = '0;
        z_bits = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset size: a few points along row 0, then the row is cut short mid-way.
        send_point(F_ZERO, F_ZERO, F_ZERO);
        send_point(F_MAX, F_NEG_MAX, F_NEG_ZERO);
        send_point(NEG_ONE_BITS, F_ONE, F_ONE);
        send_point(F_ONE, NEG_ONE_BITS, NEG_ONE_BITS);
        wait_for_idle();
        write_reg(CFG_COLUMNS, 13'd3);
        send_point(F_NEG_ZERO, F_MIN_SUB, F_ONE);

        // Last row of a 3 by 2 grid: one quad closes, the next cell has a missing corner.
        wait_for_idle();
        write_reg(CFG_ROWS, 13'd2);
        send_point(F_ONE, F_ONE, F_ONE);
        send_point(F_NEG_MAX, F_MAX, F_MIN_SUB);
        send_point(F_MIN_SUB, F_NEG_ZERO, F_MAX);

        // A zero column count and an oversized row count, then a row cut below the position.
        wait_for_idle();
        write_reg(CFG_COLUMNS, 13'd0);
        write_reg(CFG_ROWS, 13'd8191);
        send_point(F_ONE, F_ZERO, F_ONE);
        send_point(F_ZERO, F_ONE, F_ZERO);
        send_point(F_MAX, F_MAX, F_MAX);
        wait_for_idle();
        write_reg(CFG_ROWS, 13'd1);
        send_point(F_NEG_MAX, F_NEG_MAX, F_NEG_MAX);

        // An oversized column count and a zero row count, then a column cut.
        wait_for_idle();
        write_reg(CFG_COLUMNS, 13'd8191);
        write_reg(CFG_ROWS, 13'd0);
        send_point(F_ONE, F_ONE, F_ZERO);
        send_point(F_ZERO, F_ZERO, F_ONE);
        wait_for_idle();
        write_reg(CFG_COLUMNS, 13'd2);
        send_point(F_ONE, F_NEG_ZERO, F_NEG_ZERO);

        // Two 2 by 2 grids: one full quad, then NaN in x and infinity in y and in z.
        wait_for_idle();
        write_reg(CFG_ROWS, 13'd2);
        send_point(F_ZERO, F_ONE, F_MAX);
        send_point(F_ONE, F_ZERO, F_NEG_MAX);
        send_point(F_MAX, F_NEG_ZERO, F_ONE);
        send_point(F_NEG_MAX, F_MIN_SUB, F_ZERO);
        send_point(F_NAN, F_ONE, F_ONE);
        send_point(F_ONE, F_INF, F_ONE);
        send_point(F_ONE, F_ONE, F_NEG_INF);
        send_point(F_ZERO, F_ZERO, F_ZERO);

        // Random phases: small grids mostly, with a possible resize at each phase boundary.
        while (points_sent < 25 + RANDOM_POINTS)
        begin
            wait_for_idle();
            phase_count++;

            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 19))
                    0: cols_val = CFG_W'($urandom_range(4097, 8191));
                    1: cols_val = 13'd4096;
                    2: cols_val = 13'd0;
                    3: cols_val = 13'd1;
                    default: cols_val = CFG_W'($urandom_range(2, 12));
                endcase
                // Past row 0 a row may only shrink, so every line store read hits a written entry.
                if (grid_row != 0 && cols_val > active_columns)
                    cols_val = CFG_W'($urandom_range(0, active_columns));
                write_reg(CFG_COLUMNS, cols_val);
            end

            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 19))
                    0: rows_val = CFG_W'($urandom_range(4097, 8191));
                    1: rows_val = 13'd4096;
                    2: rows_val = 13'd0;
                    3: rows_val = 13'd1;
                    default: rows_val = CFG_W'($urandom_range(1, 10));
                endcase
                write_reg(CFG_ROWS, rows_val);
            end

            // The closing stretch of the run has no idling on either side.
            if (points_sent >= 25 + RANDOM_POINTS - CALM_POINTS)
                idle_enable = 1'b0;

            phase_points = $urandom_range(8, 50);
            if (phase_count == HOLD_PHASE)
            begin
                long_hold_req = 1'b1;
                phase_points = 40;
            end

            repeat (phase_points)
            begin
                make_point(px, py, pz);
                send_point(px, py, pz);
            end
        end

        wait_for_idle();

        $display("Covered %0d points over %0d resize phases, including clamped sizes, cuts",
                 points_sent, phase_count);
        $display("mid-grid and a long output hold-off; %0d vertex and %0d quad records checked.",
                 vertex_records, quad_records);
        if (fail_count == 0 && pending_records == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gsqm_pkg.sv
rtl/gsqm_ram.sv
rtl/grid_surface_quad_mesh_unit.sv
tb/grid_surface_quad_mesh_unit_checker.sv
tb/grid_surface_quad_mesh_unit_tb.sv
